/* src/sdaf_pkg.sv */
// Shared types, constants and helper functions of the signed decimal ASCII formatter.
`default_nettype none

package sdaf_pkg;

  localparam int VALUE_W    = 18;
  localparam int MAG_W      = 17;
  localparam int NUM_DIGITS = 5;
  localparam int DIG_W      = 4;
  localparam int IDX_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int SDATA_W    = 24;
  localparam int MDATA_W    = 8;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 17'd99999;

  // weights of the four leading digits; the units digit is what remains
  localparam logic [MAG_W-1:0] WEIGHTS [0:3] = '{17'd10000, 17'd1000, 17'd100, 17'd10};

  localparam logic FMT_INT  = 1'b0;
  localparam logic FMT_HUND = 1'b1;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

  localparam logic [IDX_W-1:0] IDX_POINT    = 3'd3;
  localparam logic [IDX_W-1:0] IDX_END_INT  = 3'd4;
  localparam logic [IDX_W-1:0] IDX_END_HUND = 3'd5;

  // one number in flight through the digit pipeline
  typedef struct packed {
    logic                  fmt;
    logic                  neg;
    logic [MAG_W-1:0]      rem;
    logic [3:0][DIG_W-1:0] dig;
  } fstg_t;

  // classified number handed from front to back
  typedef struct packed {
    logic                           fmt;
    logic                           neg;
    logic [NUM_DIGITS-1:0][DIG_W-1:0] dig;
    logic [IDX_W-1:0]               lead;
  } qent_t;

  // decimal digit of n at weight w, n below ten times w
  function automatic logic [DIG_W-1:0] digit_at(input logic [MAG_W-1:0] n,
                                                input logic [MAG_W-1:0] w);
    logic [DIG_W-1:0] d;
    d = '0;
    for (int m = 1; m <= 9; m++) begin
      if (n >= MAG_W'(m) * w) d = DIG_W'(m);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* src/signed_decimal_ascii_formatter.sv */
// Top level of the signed decimal ASCII formatter.
`default_nettype none

// Prints a signed number as decimal ASCII text, one character per output
// request, tlast on the final character. tuser selects the format: 0 plain
// integer, 1 hundredths with a decimal point and two fraction digits. Values
// beyond +/-99999 saturate. The input side takes one request per cycle, unless
// a full queue stalls it, into a six-stage pipeline (input register, magnitude
// with saturation, then one stage for each of the four leading decimal digits,
// the units digit being what remains), followed by a two-entry queue. The
// output side emits one character per cycle while m_tready is high, so a number
// occupies it for 1 to 7 characters (sign, digits, point); that character count
// sets the sustained rate. The first character appears once the number has
// passed the pipeline and the queue and been loaded into the back end.
module signed_decimal_ascii_formatter
  import sdaf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire logic [SDATA_W-1:0] s_tdata,   // [17:0] value, [23:18] zero
  input  wire logic               s_tuser,   // [0] req_type
  output      logic               m_tvalid,
  input  wire logic               m_tready,
  output      logic [MDATA_W-1:0] m_tdata,   // [7:0] ascii_char
  output      logic               m_tlast
);

  logic  push;
  logic  push_ready;
  qent_t push_data;
  logic  pop;
  logic  pop_valid;
  qent_t pop_data;

  sdaf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_fmt     (s_tuser),
    .in_value   (s_tdata[VALUE_W-1:0]),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sdaf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  sdaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

/* src/sdaf_front.sv */
// Front end: accepts requests, forms the saturated magnitude, extracts digits, classifies.
`default_nettype none

module sdaf_front
  import sdaf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_fmt,
  input  wire logic [VALUE_W-1:0] in_value,
  output      logic               push,
  input  wire logic               push_ready,
  output      qent_t              push_data
);

  logic               raw_vld;
  logic               raw_fmt;
  logic [VALUE_W-1:0] raw_val;
  logic [4:0]         dvld;
  fstg_t              dstg [0:4];
  fstg_t              dnext [0:3];
  fstg_t              mag_next;
  logic [VALUE_W-1:0] mag_wide;
  logic               advance;

  // whole pipeline moves together; it stalls only when its tail cannot leave
  assign advance  = !dvld[4] || push_ready;
  assign in_ready = advance;
  assign push     = dvld[4] && push_ready;

  always_comb begin
    mag_wide         = raw_val[VALUE_W-1] ? (~raw_val + 1'b1) : raw_val;
    mag_next.fmt     = raw_fmt;
    mag_next.neg     = raw_val[VALUE_W-1];
    mag_next.dig     = '0;
    if (mag_wide > {1'b0, MAG_LIMIT}) begin
      mag_next.rem = MAG_LIMIT;
    end else begin
      mag_next.rem = mag_wide[MAG_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [DIG_W-1:0] d;
      d            = digit_at(dstg[k].rem, WEIGHTS[k]);
      dnext[k]     = dstg[k];
      dnext[k].dig[k] = d;
      dnext[k].rem = dstg[k].rem - MAG_W'(d) * WEIGHTS[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_vld <= 1'b0;
      dvld    <= '0;
    end else if (advance) begin
      raw_vld <= in_valid;
      dvld    <= {dvld[3:0], raw_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw_fmt <= in_fmt;
      raw_val <= in_value;
      dstg[0] <= mag_next;
      for (int k = 0; k < 4; k++) begin
        dstg[k+1] <= dnext[k];
      end
    end
  end

  // classify: where the shown digits start
  always_comb begin
    push_data.fmt    = dstg[4].fmt;
    push_data.neg    = dstg[4].neg;
    push_data.dig[3:0] = dstg[4].dig;
    push_data.dig[4] = dstg[4].rem[DIG_W-1:0];
    priority if (dstg[4].dig[0] != '0) begin
      push_data.lead = 3'd0;
    end else if (dstg[4].dig[1] != '0) begin
      push_data.lead = 3'd1;
    end else if (dstg[4].fmt == FMT_HUND) begin
      push_data.lead = 3'd2;
    end else if (dstg[4].dig[2] != '0) begin
      push_data.lead = 3'd2;
    end else if (dstg[4].dig[3] != '0) begin
      push_data.lead = 3'd3;
    end else begin
      push_data.lead = 3'd4;
    end
  end

endmodule

`default_nettype wire

/* src/sdaf_queue.sv */
// Two-entry queue between the front and back ends.
`default_nettype none

module sdaf_queue
  import sdaf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output      logic  push_ready,
  input  wire qent_t push_data,
  input  wire logic  pop,
  output      logic  pop_valid,
  output      qent_t pop_data
);

  qent_t      entry [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

/* src/sdaf_back.sv */
// Back end: walks one classified number out as ASCII characters, one per cycle while the output is ready.
`default_nettype none

module sdaf_back
  import sdaf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire qent_t               q_data,
  output      logic                pop,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [CHAR_W-1:0]   out_char,
  output      logic                out_last
);

  qent_t            cur;
  logic             busy;
  logic             sign_pend;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_end;
  logic [IDX_W-1:0] dsel;
  logic             take;

  assign idx_end   = (cur.fmt == FMT_HUND) ? IDX_END_HUND : IDX_END_INT;
  assign out_valid = busy;
  assign out_last  = !sign_pend && (idx == idx_end);
  assign take      = out_valid && out_ready;
  assign pop       = q_valid && (!busy || (take && out_last));

  // fraction digits sit one place beyond the point
  assign dsel = (cur.fmt == FMT_HUND && idx > IDX_POINT) ? idx - 3'd1 : idx;

  always_comb begin
    priority if (sign_pend) begin
      out_char = CH_MINUS;
    end else if (cur.fmt == FMT_HUND && idx == IDX_POINT) begin
      out_char = CH_POINT;
    end else begin
      out_char = CH_ZERO + {4'b0, cur.dig[dsel]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      sign_pend <= q_data.neg;
      idx       <= q_data.lead;
    end else if (take) begin
      if (out_last) begin
        busy <= 1'b0;
      end else if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
  end

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= idx_end))
    else $error("character index beyond end of number");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char == CH_MINUS) |-> !out_last)
    else $error("sign emitted as final character");

  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    (take && out_last && !q_valid) |=> !out_valid)
    else $error("output still valid after final character with empty queue");

  a_sign_holds_idx: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy) && sign_pend && !$past(pop)) |-> $stable(idx))
    else $error("index moved while sign pending");
`endif

endmodule

`default_nettype wire
